[sv/alm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alm_pkg: shared types and constants of the audio level meter.
// Holds sample widths, accumulator widths and the lane snapshot struct.
// ----------------------------------------------------------------------------
package alm_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned ExtW    = 17;
  localparam int unsigned SumW    = 41;
  localparam int unsigned SqW     = 56;
  localparam int unsigned CntW    = 25;
  localparam int unsigned PhysCh  = 3;
  localparam int unsigned FullScale = 32'h8000;

  // Snapshot of one lane at the close of a block.
  typedef struct packed {
    logic [SampleW-1:0] amp;
    logic [SumW-1:0]    sum;
    logic [SqW-1:0]     sq;
  } lane_snap_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_OUT
  } stat_state_e;

endpackage : alm_pkg
`default_nettype wire

[sv/alm_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alm_stream_if: valid/ready channel with a generic payload.
// One word moves at each edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface alm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : alm_stream_if
`default_nettype wire

[sv/alm_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alm_lane: accumulator lane for one channel.
// Tracks minimum, maximum, sum and sum of squares of the samples.
// ----------------------------------------------------------------------------
module alm_lane (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           close_i,
  input  wire logic [alm_pkg::SampleW-1:0]    sample_i,
  output alm_pkg::lane_snap_t                 snap_o
);
  import alm_pkg::*;

  logic signed [ExtW-1:0] min_q, max_q, min_n, max_n, s_ext;
  logic signed [SumW-1:0] sum_q, sum_n;
  logic [SqW-1:0]         sq_q, sq_n;
  logic [31:0]            prod;
  logic [ExtW-1:0]        amin, amax;

  assign s_ext = ExtW'($signed(sample_i));
  assign prod  = 32'($signed(sample_i) * $signed(sample_i));

  // Values that include the current frame.
  always_comb begin
    min_n = (s_ext < min_q) ? s_ext : min_q;
    max_n = (s_ext > max_q) ? s_ext : max_q;
    sum_n = sum_q + SumW'(s_ext);
    sq_n  = sq_q + SqW'(prod);
    amin  = min_n[ExtW-1] ? ExtW'(-min_n) : ExtW'(min_n);
    amax  = max_n[ExtW-1] ? ExtW'(-max_n) : ExtW'(max_n);
    snap_o.amp = (amin > amax) ? amin[SampleW-1:0] : amax[SampleW-1:0];
    snap_o.sum = sum_n;
    snap_o.sq  = sq_n;
  end

  // Accumulators; a closing frame returns them to their cleared values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= ExtW'(FullScale);
      max_q <= -ExtW'(FullScale);
      sum_q <= '0;
      sq_q  <= '0;
    end else if (en_i) begin
      if (close_i) begin
        min_q <= ExtW'(FullScale);
        max_q <= -ExtW'(FullScale);
        sum_q <= '0;
        sq_q  <= '0;
      end else begin
        min_q <= min_n;
        max_q <= max_n;
        sum_q <= sum_n;
        sq_q  <= sq_n;
      end
    end
  end

endmodule : alm_lane
`default_nettype wire

[sv/alm_stats.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alm_stats: merging stage that turns lane snapshots into results.
// One shared divider and one shared square-root unit, one bit per cycle.
// ----------------------------------------------------------------------------
module alm_stats #(
  parameter int unsigned NCH = 3
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire alm_pkg::lane_snap_t         snap_i [NCH],
  input  wire logic [alm_pkg::CntW-1:0]    count_i,
  input  wire logic                        trunc_i,
  output logic                             busy_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [1:0]                       out_ch_o,
  output logic [15:0]                      out_amp_o,
  output logic [15:0]                      out_off_o,
  output logic [15:0]                      out_rms_o,
  output logic [16:0]                      out_frames_o,
  output logic                             out_trunc_o,
  output logic                             out_last_o
);
  import alm_pkg::*;

  localparam int unsigned ChW = (NCH > 1) ? $clog2(NCH) : 1;

  stat_state_e state_q, state_d;
  lane_snap_t  snap_q [NCH];
  logic [CntW-1:0] cnt_q;
  logic            trunc_q;
  logic [ChW-1:0]  ch_q;
  logic [6:0]      step_q;
  logic [1:0]      phase_q;  // 0 sum divide, 1 sumsq divide
  // Restoring divider.
  logic [SqW-1:0]  dq_q;
  logic [CntW-1:0] rem_q;
  logic            sneg_q;
  logic [15:0]     off_q;
  // Square root, two bits per step.
  logic [SqW-1:0]  rv_q;
  logic [SqW/2+1:0] root_q;
  logic [SqW/2+3:0] rr_q, rr_sh, trial;
  // Output register.
  logic            ov_q;
  logic [1:0]      och_q;
  logic [15:0]     oamp_q, ooff_q, orms_q;
  logic [16:0]     ofr_q;
  logic            otr_q, olast_q;

  lane_snap_t cur;
  logic [SumW-1:0] sabs;
  logic            op_end;
  logic            take;
  logic            ch_last;

  assign cur = snap_q[ch_q];
  assign sabs = cur.sum[SumW-1] ? SumW'(-cur.sum) : cur.sum;
  assign rr_sh  = {rr_q[SqW/2+1:0], rv_q[SqW-1:SqW-2]};
  assign trial  = {root_q, 2'b01};
  assign ch_last = (32'(ch_q) == NCH - 1);
  // A finished word moves on when the output register is free or being emptied.
  assign take = (state_q == ST_OUT) && (!ov_q || out_ready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_DIV;
      ST_DIV:  if (step_q == 7'(SqW - 1) && phase_q == 2'd1) state_d = ST_SQRT;
      ST_SQRT: if (step_q == 7'(SqW/2 - 1)) state_d = ST_OUT;
      ST_OUT:  if (take) state_d = ch_last ? ST_IDLE : ST_DIV;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy_o      = (state_q != ST_IDLE);
    out_valid_o = ov_q;
    op_end      = take && ch_last;
  end

  assign out_ch_o     = och_q;
  assign out_amp_o    = oamp_q;
  assign out_off_o    = ooff_q;
  assign out_rms_o    = orms_q;
  assign out_frames_o = ofr_q;
  assign out_trunc_o  = otr_q;
  assign out_last_o   = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // Datapath of the shared divider and square root.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0; step_q <= '0; phase_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          ch_q <= '0; step_q <= '0; phase_q <= '0;
        end
        ST_DIV: begin
          if (step_q == 7'(SqW - 1)) begin
            step_q  <= '0;
            phase_q <= (phase_q == 2'd0) ? 2'd1 : 2'd0;
          end else begin
            step_q <= step_q + 7'd1;
          end
        end
        ST_SQRT: step_q <= (step_q == 7'(SqW/2 - 1)) ? 7'd0 : step_q + 7'd1;
        ST_OUT:  if (take && !op_end) ch_q <= ch_q + ChW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      snap_q  <= snap_i;
      cnt_q   <= count_i;
      trunc_q <= trunc_i;
    end
    if (state_q == ST_DIV) begin
      logic [SqW-1:0]  dq;
      logic [CntW-1:0] rm;
      logic [CntW:0]   rs;
      logic [SqW-1:0]  q;
      dq = (step_q == 7'd0) ? ((phase_q == 2'd0) ? SqW'(sabs) : cur.sq) : dq_q;
      rm = (step_q == 7'd0) ? '0 : rem_q;
      rs = {rm, dq[SqW-1]};
      q  = {dq[SqW-2:0], 1'b0};
      if (rs >= {1'b0, cnt_q}) begin
        rs = rs - {1'b0, cnt_q};
        q[0] = 1'b1;
      end
      dq_q  <= q;
      rem_q <= rs[CntW-1:0];
      if (step_q == 7'(SqW - 1) && phase_q == 2'd0)
        off_q <= cur.sum[SumW-1] ? 16'(-q) : q[15:0];
      if (step_q == 7'(SqW - 1) && phase_q == 2'd1) begin
        rv_q   <= q;
        root_q <= '0;
        rr_q   <= '0;
      end
    end
    if (state_q == ST_SQRT) begin
      rv_q <= {rv_q[SqW-3:0], 2'b00};
      if (rr_sh >= trial) begin
        rr_q   <= rr_sh - trial;
        root_q <= {root_q[SqW/2:0], 1'b1};
      end else begin
        rr_q   <= rr_sh;
        root_q <= {root_q[SqW/2:0], 1'b0};
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (take) ov_q <= 1'b1;
    else if (out_ready_i) ov_q <= 1'b0;
  end

  // Output register payload, loaded with each finished word.
  always_ff @(posedge clk_i) begin
    if (take) begin
      och_q   <= 2'(ch_q);
      oamp_q  <= cur.amp;
      ooff_q  <= off_q;
      orms_q  <= root_q[15:0];
      ofr_q   <= cnt_q[16:0];
      otr_q   <= trunc_q;
      olast_q <= ch_last;
    end
  end

  // The result must describe a channel that exists.
  a_ch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(och_q) < NCH) else $error("channel out of range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(och_q))
    else $error("result dropped while stalled");
  a_no_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !start_i) else $error("block closed while busy");

endmodule : alm_stats
`default_nettype wire

[sv/multichannel_audio_level_meter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_audio_level_meter: peak, offset and RMS meter per channel.
// Parallel accumulator lanes feed one shared divide and square-root stage.
// ----------------------------------------------------------------------------
// Frames are taken one per cycle while no block is being reported. When a
// block closes (block_end, or the frame bound reached), a result word per
// channel follows; each channel passes through the shared bit-serial unit
// (two 56-step divides and a 28-step square root) and then hands its word
// to the output register once that register is free or being emptied,
// and no frame is accepted until the last result word of the block has
// entered the output register.
module multichannel_audio_level_meter #(
  parameter int unsigned CHANNELS         = 3,
  parameter int unsigned MAX_BLOCK_FRAMES = 65536
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  alm_stream_if.sink   in_i,
  alm_stream_if.source out_o
);
  import alm_pkg::*;

  localparam int unsigned NCH = (CHANNELS < PhysCh) ? CHANNELS : PhysCh;

  logic            busy, acc, close, endf, bound, ov;
  logic [CntW-1:0] cnt_q, cnt_n;
  lane_snap_t      snap [NCH];
  logic [SampleW-1:0] samp [PhysCh];

  assign samp[0] = in_i.data.sample_ch0;
  assign samp[1] = in_i.data.sample_ch1;
  assign samp[2] = in_i.data.sample_ch2;

  assign in_i.ready = !busy;
  assign acc   = in_i.valid && in_i.ready;
  assign endf  = in_i.data.block_end;
  assign cnt_n = cnt_q + CntW'(1);
  assign bound = (cnt_n >= CntW'(MAX_BLOCK_FRAMES));
  assign close = endf || bound;

  // Frame counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (acc) cnt_q <= close ? '0 : cnt_n;
  end

  // One lane per channel.
  for (genvar g = 0; g < NCH; g++) begin : g_lane
    alm_lane u_lane (
      .clk_i, .rst_ni, .en_i(acc), .close_i(close),
      .sample_i(samp[g]), .snap_o(snap[g])
    );
  end

  alm_stats #(.NCH(NCH)) u_stats (
    .clk_i, .rst_ni,
    .start_i(acc && close),
    .snap_i(snap),
    .count_i(cnt_n),
    .trunc_i(!endf),
    .busy_o(busy),
    .out_valid_o(ov),
    .out_ready_i(out_o.ready),
    .out_ch_o(out_o.data.channel),
    .out_amp_o(out_o.data.amplitude),
    .out_off_o(out_o.data.offset),
    .out_rms_o(out_o.data.rms_level),
    .out_frames_o(out_o.data.frames),
    .out_trunc_o(out_o.data.truncated),
    .out_last_o(out_o.data.last)
  );
  assign out_o.valid = ov;

  a_frames: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CntW'(MAX_BLOCK_FRAMES)) else $error("frame count beyond bound");
  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && close |=> busy) else $error("close did not start report");
  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_i.ready) else $error("frame accepted while reporting");

endmodule : multichannel_audio_level_meter
`default_nettype wire
